// ----- rtl/core/dtp_pkg.sv -----
// Shared types, register indexes and constants of the disparity-to-point core.
package dtp_pkg;

  localparam int DISP_W  = 16;
  localparam int PIX_W   = 12;
  localparam int FB_W    = 26;
  localparam int DEPTH_W = 16;
  localparam int FOCAL_W = 18;
  localparam int CTR_W   = 16;
  localparam int COORD_W = 24;
  localparam int MAG_W   = CTR_W + DEPTH_W;
  localparam int CFG_W   = FB_W;
  localparam int IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_FOCAL_BASELINE = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN_DEPTH      = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAX_DEPTH      = 3'd2;
  localparam logic [IDX_W-1:0] REG_FOCAL_X        = 3'd3;
  localparam logic [IDX_W-1:0] REG_FOCAL_Y        = 3'd4;
  localparam logic [IDX_W-1:0] REG_CENTER_X       = 3'd5;
  localparam logic [IDX_W-1:0] REG_CENTER_Y       = 3'd6;

  localparam logic [FB_W-1:0]    RST_FOCAL_BASELINE = 26'd1310816;
  localparam logic [DEPTH_W-1:0] RST_MIN_DEPTH      = 16'd320;
  localparam logic [DEPTH_W-1:0] RST_MAX_DEPTH      = 16'd20000;
  localparam logic [FOCAL_W-1:0] RST_FOCAL_X        = 18'd6893;
  localparam logic [FOCAL_W-1:0] RST_FOCAL_Y        = 18'd6895;
  localparam logic [CTR_W-1:0]   RST_CENTER_X       = 16'd6848;
  localparam logic [CTR_W-1:0]   RST_CENTER_Y       = 16'd3950;

  localparam logic [COORD_W-1:0] SAT_POS     = 24'h7F_FFFF;
  localparam logic [COORD_W-1:0] SAT_NEG_MAG = 24'h80_0000;

  typedef struct packed {
    logic [FB_W-1:0]    focal_baseline;
    logic [DEPTH_W-1:0] min_depth;
    logic [DEPTH_W-1:0] max_depth;
    logic [FOCAL_W-1:0] focal_x;
    logic [FOCAL_W-1:0] focal_y;
    logic [CTR_W-1:0]   center_x;
    logic [CTR_W-1:0]   center_y;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] x_mm;
    logic [COORD_W-1:0] y_mm;
    logic [DEPTH_W-1:0] z_mm;
  } point_t;

endpackage

// ----- rtl/core/disparity_to_point_xyz_core.sv -----
// Disparity-to-point core: converts one disparity pixel per clock into an X/Y/Z point in mm
// while the stages advance and returns one point per pixel, in order. Stages: one input
// stage, a 26-stage bit-per-stage divider for depth, a clamp stage, then offset, multiply,
// a 32-stage divider for X and Y in parallel and a saturate stage. All stages advance
// together while the two-entry output buffer has room or is being read, so input keeps
// flowing while one finished point waits. Depth is focal_baseline over disparity clamped
// to the min/max limits; zero disparity gives the max limit. The user must write registers
// through cfg_write/cfg_index/cfg_data only while no pixel is in flight (not enforced).
module disparity_to_point_xyz_core #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [dtp_pkg::IDX_W-1:0]     cfg_index,
  input  logic [dtp_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dtp_pkg::DISP_W-1:0]    disparity,
  input  logic [dtp_pkg::PIX_W-1:0]     column,
  input  logic [dtp_pkg::PIX_W-1:0]     row,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dtp_pkg::COORD_W-1:0]   x_mm,
  output logic [dtp_pkg::COORD_W-1:0]   y_mm,
  output logic [dtp_pkg::DEPTH_W-1:0]   z_mm
);
  import dtp_pkg::*;

  cfg_t               cfg;
  logic               en;
  logic               depth_valid;
  logic [DEPTH_W-1:0] depth_z;
  logic [PIX_W-1:0]   depth_col;
  logic [PIX_W-1:0]   depth_row;
  logic               x_valid;
  logic [COORD_W-1:0] x_coord;
  logic [DEPTH_W-1:0] x_z;
  logic [COORD_W-1:0] y_coord;
  point_t             point_in;
  point_t             point_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_baseline <= RST_FOCAL_BASELINE;
      cfg.min_depth      <= RST_MIN_DEPTH;
      cfg.max_depth      <= RST_MAX_DEPTH;
      cfg.focal_x        <= RST_FOCAL_X;
      cfg.focal_y        <= RST_FOCAL_Y;
      cfg.center_x       <= RST_CENTER_X;
      cfg.center_y       <= RST_CENTER_Y;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FOCAL_BASELINE: cfg.focal_baseline <= cfg_data;
        REG_MIN_DEPTH:      cfg.min_depth      <= cfg_data[DEPTH_W-1:0];
        REG_MAX_DEPTH:      cfg.max_depth      <= cfg_data[DEPTH_W-1:0];
        REG_FOCAL_X:        cfg.focal_x        <= cfg_data[FOCAL_W-1:0];
        REG_FOCAL_Y:        cfg.focal_y        <= cfg_data[FOCAL_W-1:0];
        REG_CENTER_X:       cfg.center_x       <= cfg_data[CTR_W-1:0];
        REG_CENTER_Y:       cfg.center_y       <= cfg_data[CTR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = en;

  dtp_depth #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_depth (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cfg      (cfg),
    .in_valid (in_valid),
    .disparity(disparity),
    .column   (column),
    .row      (row),
    .out_valid(depth_valid),
    .z        (depth_z),
    .col_out  (depth_col),
    .row_out  (depth_row)
  );

  dtp_project u_proj_x (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (depth_valid),
    .pix      (depth_col),
    .center   (cfg.center_x),
    .focal    (cfg.focal_x),
    .z        (depth_z),
    .out_valid(x_valid),
    .coord    (x_coord),
    .z_out    (x_z)
  );

  dtp_project u_proj_y (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (depth_valid),
    .pix      (depth_row),
    .center   (cfg.center_y),
    .focal    (cfg.focal_y),
    .z        (depth_z),
    .out_valid(),
    .coord    (y_coord),
    .z_out    ()
  );

  assign point_in.x_mm = x_coord;
  assign point_in.y_mm = y_coord;
  assign point_in.z_mm = x_z;

  dtp_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (x_valid),
    .in_point (point_in),
    .en       (en),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_point(point_out)
  );

  assign x_mm = point_out.x_mm;
  assign y_mm = point_out.y_mm;
  assign z_mm = point_out.z_mm;

endmodule

// ----- rtl/core/dtp_pipe_div.sv -----
// Pipelined restoring divider: one quotient bit per register stage.
module dtp_pipe_div #(
  parameter int NW = 26,
  parameter int DW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic [SW-1:0] out_side
);

  logic          valid_q [NW];
  logic [DW-1:0] rem_q   [NW];
  logic [NW-1:0] nq_q    [NW];
  logic [DW-1:0] den_q   [NW];
  logic [SW-1:0] side_q  [NW];

  for (genvar i = 0; i < NW; i++) begin : g_step
    logic          valid_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] nq_in;
    logic [DW-1:0] den_in;
    logic [SW-1:0] side_in;
    logic [DW:0]   trial;
    logic          fit;

    if (i == 0) begin : g_first
      assign valid_in = in_valid;
      assign rem_in   = '0;
      assign nq_in    = num;
      assign den_in   = den;
      assign side_in  = side;
    end else begin : g_next
      assign valid_in = valid_q[i-1];
      assign rem_in   = rem_q[i-1];
      assign nq_in    = nq_q[i-1];
      assign den_in   = den_q[i-1];
      assign side_in  = side_q[i-1];
    end

    assign trial = {rem_in, nq_in[NW-1]};
    assign fit   = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_q[i] <= 1'b0;
      end else if (en) begin
        valid_q[i] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= fit ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        nq_q[i]   <= {nq_in[NW-2:0], fit};
        den_q[i]  <= den_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign out_valid = valid_q[NW-1];
  assign quo       = nq_q[NW-1];
  assign out_side  = side_q[NW-1];

endmodule

// ----- rtl/core/dtp_depth.sv -----
// Depth path: pixel clamp, focal-baseline over disparity, depth clamp.
module dtp_depth #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  dtp_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  input  logic [dtp_pkg::DISP_W-1:0]    disparity,
  input  logic [dtp_pkg::PIX_W-1:0]     column,
  input  logic [dtp_pkg::PIX_W-1:0]     row,
  output logic                          out_valid,
  output logic [dtp_pkg::DEPTH_W-1:0]   z,
  output logic [dtp_pkg::PIX_W-1:0]     col_out,
  output logic [dtp_pkg::PIX_W-1:0]     row_out
);
  import dtp_pkg::*;

  localparam longint unsigned ColMax = longint'(MAX_WIDTH) - 1;
  localparam longint unsigned RowMax = longint'(MAX_HEIGHT) - 1;

  logic               valid_a;
  logic [DISP_W-1:0]  disp_a;
  logic [PIX_W-1:0]   col_a;
  logic [PIX_W-1:0]   row_a;
  logic [PIX_W-1:0]   col_next;
  logic [PIX_W-1:0]   row_next;

  logic               div_valid;
  logic [FB_W-1:0]    quo;
  logic [2*PIX_W-1:0] div_side;
  logic [FB_W-1:0]    z_low;
  logic [DEPTH_W-1:0] z_next;

  always_comb begin
    col_next = (64'(column) > 64'(ColMax)) ? PIX_W'(ColMax) : column;
    row_next = (64'(row) > 64'(RowMax)) ? PIX_W'(RowMax) : row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (en) begin
      valid_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      disp_a <= disparity;
      col_a  <= col_next;
      row_a  <= row_next;
    end
  end

  dtp_pipe_div #(
    .NW(FB_W),
    .DW(DISP_W),
    .SW(2*PIX_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (valid_a),
    .num      (cfg.focal_baseline),
    .den      (disp_a),
    .side     ({col_a, row_a}),
    .out_valid(div_valid),
    .quo      (quo),
    .out_side (div_side)
  );

  // A zero disparity divides to all ones and so clamps to the upper limit.
  always_comb begin
    z_low  = (quo < FB_W'(cfg.min_depth)) ? FB_W'(cfg.min_depth) : quo;
    z_next = (z_low > FB_W'(cfg.max_depth)) ? cfg.max_depth : z_low[DEPTH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z       <= z_next;
      col_out <= div_side[2*PIX_W-1:PIX_W];
      row_out <= div_side[PIX_W-1:0];
    end
  end

endmodule

// ----- rtl/core/dtp_project.sv -----
// Projection path: offset from principal point, times depth, over focal length.
module dtp_project (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [dtp_pkg::PIX_W-1:0]     pix,
  input  logic [dtp_pkg::CTR_W-1:0]     center,
  input  logic [dtp_pkg::FOCAL_W-1:0]   focal,
  input  logic [dtp_pkg::DEPTH_W-1:0]   z,
  output logic                          out_valid,
  output logic [dtp_pkg::COORD_W-1:0]   coord,
  output logic [dtp_pkg::DEPTH_W-1:0]   z_out
);
  import dtp_pkg::*;

  localparam int SideW = DEPTH_W + 2;

  logic               valid_a;
  logic [CTR_W-1:0]   off_a;
  logic               neg_a;
  logic [DEPTH_W-1:0] z_a;
  logic [CTR_W-1:0]   p16;
  logic               neg_next;

  logic               valid_b;
  logic [MAG_W-1:0]   mag_b;
  logic               neg_b;
  logic [DEPTH_W-1:0] z_b;

  logic               div_valid;
  logic [MAG_W-1:0]   quo;
  logic [SideW-1:0]   div_side;
  logic               div_neg;
  logic               div_zero;
  logic [COORD_W-1:0] sat_mag;
  logic [COORD_W-1:0] coord_next;

  assign p16      = {pix, 4'b0000};
  assign neg_next = center > p16;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
    end else if (en) begin
      valid_a <= in_valid;
      valid_b <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      off_a <= neg_next ? (center - p16) : (p16 - center);
      neg_a <= neg_next;
      z_a   <= z;
      mag_b <= MAG_W'(off_a) * MAG_W'(z_a);
      neg_b <= neg_a;
      z_b   <= z_a;
    end
  end

  dtp_pipe_div #(
    .NW(MAG_W),
    .DW(FOCAL_W),
    .SW(SideW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (valid_b),
    .num      (mag_b),
    .den      (focal),
    .side     ({neg_b, (mag_b == '0), z_b}),
    .out_valid(div_valid),
    .quo      (quo),
    .out_side (div_side)
  );

  assign div_neg  = div_side[SideW-1];
  assign div_zero = div_side[SideW-2];

  // A zero focal length divides to all ones and so saturates, unless the product is zero.
  always_comb begin
    if (div_neg) begin
      sat_mag    = (quo > MAG_W'(SAT_NEG_MAG)) ? SAT_NEG_MAG : quo[COORD_W-1:0];
      coord_next = COORD_W'(0) - sat_mag;
    end else begin
      sat_mag    = (quo > MAG_W'(SAT_POS)) ? SAT_POS : quo[COORD_W-1:0];
      coord_next = sat_mag;
    end
    if (div_zero) begin
      coord_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coord <= coord_next;
      z_out <= div_side[DEPTH_W-1:0];
    end
  end

endmodule

// ----- rtl/core/dtp_out_buf.sv -----
// Two-entry output buffer that sets the pipeline advance enable.
module dtp_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  dtp_pkg::point_t in_point,
  output logic            en,
  output logic            out_valid,
  input  logic            out_ready,
  output dtp_pkg::point_t out_point
);
  import dtp_pkg::*;

  logic [1:0] count;
  logic [1:0] count_next;
  point_t     slot0;
  point_t     slot1;
  logic       push;
  logic       pop;

  assign out_valid = count != 2'd0;
  assign out_point = slot0;
  assign en        = (count != 2'd2) || out_ready;
  assign push      = in_valid && en;
  assign pop       = out_valid && out_ready;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        slot0 <= slot1;
        if (push) begin
          slot1 <= in_point;
        end
      end else if (push) begin
        slot0 <= in_point;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= in_point;
      end else begin
        slot1 <= in_point;
      end
    end
  end

endmodule

// ----- tb/sv/point_xyz_checker.sv -----
// Watches the pixel, point and register ports, predicts each point and compares it.
module point_xyz_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [dtp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [dtp_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [dtp_pkg::DISP_W-1:0]  disparity,
  input  logic [dtp_pkg::PIX_W-1:0]   column,
  input  logic [dtp_pkg::PIX_W-1:0]   row,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [dtp_pkg::COORD_W-1:0] x_mm,
  input  logic [dtp_pkg::COORD_W-1:0] y_mm,
  input  logic [dtp_pkg::DEPTH_W-1:0] z_mm,
  output int                          mismatch_count,
  output int                          points_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import dtp_pkg::*;

  cfg_t   camera;
  point_t expected_points[$];

  function automatic logic [COORD_W-1:0] project_axis(logic [PIX_W-1:0] pix,
                                                      logic [CTR_W-1:0] center,
                                                      logic [DEPTH_W-1:0] depth,
                                                      logic [FOCAL_W-1:0] focal);
    logic [16:0] scaled_pix;
    logic [16:0] offset;
    logic        left_of_center;
    logic [33:0] magnitude;
    logic [33:0] quotient;
    logic [33:0] negated;
    scaled_pix = {1'b0, pix, 4'b0000};
    left_of_center = center > scaled_pix;
    offset = left_of_center ? 17'(center) - scaled_pix : scaled_pix - 17'(center);
    magnitude = 34'(offset) * 34'(depth);
    if (magnitude == 34'd0)
      return '0;
    if (focal == '0)
      quotient = 34'(SAT_NEG_MAG) + 34'd1;
    else
      quotient = magnitude / 34'(focal);
    if (left_of_center) begin
      if (quotient > 34'(SAT_NEG_MAG))
        quotient = 34'(SAT_NEG_MAG);
      negated = 34'd0 - quotient;
      return negated[COORD_W-1:0];
    end
    if (quotient > 34'(SAT_POS))
      quotient = 34'(SAT_POS);
    return quotient[COORD_W-1:0];
  endfunction

  function automatic point_t predict_point(cfg_t setup, logic [DISP_W-1:0] disp,
                                           logic [PIX_W-1:0] u, logic [PIX_W-1:0] v);
    logic [FB_W-1:0] depth;
    point_t          pt;
    if (disp == '0) begin
      depth = FB_W'(setup.max_depth);
    end else begin
      depth = setup.focal_baseline / FB_W'(disp);
      if (depth < FB_W'(setup.min_depth))
        depth = FB_W'(setup.min_depth);
      if (depth > FB_W'(setup.max_depth))
        depth = FB_W'(setup.max_depth);
    end
    pt.z_mm = depth[DEPTH_W-1:0];
    pt.x_mm = project_axis(u, setup.center_x, pt.z_mm, setup.focal_x);
    pt.y_mm = project_axis(v, setup.center_y, pt.z_mm, setup.focal_y);
    return pt;
  endfunction

  always @(posedge clk) begin
    point_t want;
    if (rst) begin
      camera = '{RST_FOCAL_BASELINE, RST_MIN_DEPTH, RST_MAX_DEPTH, RST_FOCAL_X,
                 RST_FOCAL_Y, RST_CENTER_X, RST_CENTER_Y};
      expected_points.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("point transfer with nothing predicted: x %0d y %0d z %0d",
                     $signed(x_mm), $signed(y_mm), z_mm);
        end else begin
          want = expected_points.pop_front();
          if (want.x_mm !== x_mm || want.y_mm !== y_mm || want.z_mm !== z_mm) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("point mismatch: expected x %0d y %0d z %0d, got x %0d y %0d z %0d",
                       $signed(want.x_mm), $signed(want.y_mm), want.z_mm,
                       $signed(x_mm), $signed(y_mm), z_mm);
          end
        end
      end
      if (in_valid && in_ready)
        expected_points.push_back(predict_point(camera, disparity, column, row));
      if (cfg_write) begin
        case (cfg_index)
          REG_FOCAL_BASELINE: camera.focal_baseline = cfg_data[FB_W-1:0];
          REG_MIN_DEPTH:      camera.min_depth      = cfg_data[DEPTH_W-1:0];
          REG_MAX_DEPTH:      camera.max_depth      = cfg_data[DEPTH_W-1:0];
          REG_FOCAL_X:        camera.focal_x        = cfg_data[FOCAL_W-1:0];
          REG_FOCAL_Y:        camera.focal_y        = cfg_data[FOCAL_W-1:0];
          REG_CENTER_X:       camera.center_x       = cfg_data[CTR_W-1:0];
          REG_CENTER_Y:       camera.center_y       = cfg_data[CTR_W-1:0];
          default: ;
        endcase
      end
    end
    points_pending = expected_points.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the disparity-to-point regression: clock, reset, pixel and register stimulus, verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dtp_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 200000;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic [IDX_W-1:0]    cfg_index;
  logic [CFG_W-1:0]    cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic [DISP_W-1:0]   disparity;
  logic [PIX_W-1:0]    column;
  logic [PIX_W-1:0]    row;
  logic                out_valid;
  logic                out_ready;
  logic [COORD_W-1:0]  x_mm;
  logic [COORD_W-1:0]  y_mm;
  logic [DEPTH_W-1:0]  z_mm;
  int                  mismatch_count;
  int                  points_pending;
  int                  cycle_count;
  int                  hold_off;
  bit                  traffic_gaps;

  disparity_to_point_xyz_core dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .disparity(disparity), .column(column), .row(row),
    .out_valid(out_valid), .out_ready(out_ready),
    .x_mm(x_mm), .y_mm(y_mm), .z_mm(z_mm)
  );

  point_xyz_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .disparity(disparity), .column(column), .row(row),
    .out_valid(out_valid), .out_ready(out_ready),
    .x_mm(x_mm), .y_mm(y_mm), .z_mm(z_mm),
    .mismatch_count(mismatch_count), .points_pending(points_pending)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : point_receiver
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = traffic_gaps ? $urandom_range(0, 4) : 0;
      if (hold_off > 0) begin
        stall = hold_off;
        hold_off = 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_pixel(input logic [DISP_W-1:0] d, input logic [PIX_W-1:0] u,
                            input logic [PIX_W-1:0] v);
    int gap;
    gap = traffic_gaps ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  = 1'b1;
    disparity = d;
    column    = u;
    row       = v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_points();
    @(negedge clk);
    in_valid = 1'b0;
    while (points_pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic load_setup(input logic [FB_W-1:0] fb, input logic [DEPTH_W-1:0] zmin,
                            input logic [DEPTH_W-1:0] zmax, input logic [FOCAL_W-1:0] fx,
                            input logic [FOCAL_W-1:0] fy, input logic [CTR_W-1:0] cx,
                            input logic [CTR_W-1:0] cy);
    write_reg(REG_FOCAL_BASELINE, CFG_W'(fb));
    write_reg(REG_MIN_DEPTH, CFG_W'(zmin));
    write_reg(REG_MAX_DEPTH, CFG_W'(zmax));
    write_reg(REG_FOCAL_X, CFG_W'(fx));
    write_reg(REG_FOCAL_Y, CFG_W'(fy));
    write_reg(REG_CENTER_X, CFG_W'(cx));
    write_reg(REG_CENTER_Y, CFG_W'(cy));
  endtask

  task automatic load_random_setup(input bit plausible);
    if (plausible)
      load_setup(FB_W'($urandom_range(200000, 3000000)), DEPTH_W'($urandom_range(0, 2000)),
                 DEPTH_W'($urandom_range(2000, 65535)), FOCAL_W'($urandom_range(2000, 20000)),
                 FOCAL_W'($urandom_range(2000, 20000)), CTR_W'($urandom_range(0, 65535)),
                 CTR_W'($urandom_range(0, 65535)));
    else
      load_setup(FB_W'($urandom_range(0, 67108863)), DEPTH_W'($urandom_range(0, 65535)),
                 DEPTH_W'($urandom_range(0, 65535)), FOCAL_W'($urandom_range(0, 262143)),
                 FOCAL_W'($urandom_range(0, 262143)), CTR_W'($urandom_range(0, 65535)),
                 CTR_W'($urandom_range(0, 65535)));
  endtask

  task automatic send_random_pixels(input int count);
    logic [DISP_W-1:0] d;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0:          d = '0;
        1, 2, 3, 4: d = DISP_W'($urandom_range(1, 2048));
        default:    d = DISP_W'($urandom_range(0, 65535));
      endcase
      send_pixel(d, PIX_W'($urandom_range(0, 4095)), PIX_W'($urandom_range(0, 4095)));
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    disparity    = '0;
    column       = '0;
    row          = '0;
    hold_off     = 0;
    traffic_gaps = 1'b1;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    send_pixel(16'd0, 12'd0, 12'd0);
    send_pixel(16'hFFFF, 12'hFFF, 12'hFFF);
    send_pixel(16'd1, 12'd4095, 12'd0);
    send_pixel(16'd32, 12'd0, 12'd4095);
    send_pixel(16'd2000, 12'd428, 12'd246);
    send_pixel(16'd5000, 12'd100, 12'd300);
    send_pixel(16'hAAAA, 12'h555, 12'hAAA);
    send_pixel(16'h5555, 12'hAAA, 12'h555);
    drain_points();

    load_setup(26'h3FF_FFFF, 16'd0, 16'hFFFF, 18'd1, 18'd0, 16'hFFFF, 16'd0);
    send_pixel(16'd1, 12'd0, 12'd4095);
    send_pixel(16'd1, 12'd4095, 12'd0);
    send_pixel(16'd0, 12'd2048, 12'd2048);
    send_pixel(16'hFFFF, 12'd1, 12'd1);
    send_pixel(16'd40, 12'd0, 12'd0);
    drain_points();

    load_setup(26'd0, 16'd0, 16'd0, 18'd0, 18'h3FFFF, 16'd0, 16'hFFF0);
    send_pixel(16'd0, 12'd0, 12'd4095);
    send_pixel(16'd500, 12'd4095, 12'd4095);
    send_pixel(16'hFFFF, 12'd17, 12'd123);
    drain_points();

    load_setup(RST_FOCAL_BASELINE, 16'd0, 16'd100, 18'h3FFFF, 18'h3FFFF, 16'd0, 16'd0);
    write_reg(REG_MIN_DEPTH, 26'h3FF_FFFF);
    write_reg(REG_UNUSED, 26'h155_5555);
    send_pixel(16'd0, 12'd4095, 12'd4095);
    send_pixel(16'd1, 12'd0, 12'd0);
    send_pixel(16'hFFFF, 12'd4095, 12'd4095);
    send_pixel(16'd3000, 12'd2000, 12'd1000);
    drain_points();

    load_setup(RST_FOCAL_BASELINE, RST_MIN_DEPTH, RST_MAX_DEPTH, RST_FOCAL_X,
               RST_FOCAL_Y, RST_CENTER_X, RST_CENTER_Y);
    for (int phase = 0; phase < 8; phase++) begin
      if (phase > 0)
        load_random_setup(phase % 4 != 3);
      traffic_gaps = (phase % 3 != 2);
      if (phase == 1) begin
        // stall the output for a long stretch while pixels keep coming
        traffic_gaps = 1'b0;
        send_random_pixels(20);
        hold_off = 400;
        send_random_pixels(190);
      end else if (phase == 4) begin
        send_random_pixels(100);
        drain_points();
        send_random_pixels(110);
      end else begin
        send_random_pixels(210);
      end
      drain_points();
    end

    repeat (80) @(negedge clk);
    if (mismatch_count == 0 && points_pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
